[hdl/priority_queue_extract_max_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the priority queue extract-max unit.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_EXTRACT_MAX_UNIT_MACROS_SVH
`define PRIORITY_QUEUE_EXTRACT_MAX_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PQX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PQX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pqx_pkg.sv]
// ---------------------------------------------------------------------------
// pqx_pkg
// Shared defaults, operation codes and the cell control type of the priority
// queue unit.
// ---------------------------------------------------------------------------
package pqx_pkg;

   // Default sizes of the queue.
   localparam int DEFAULT_DEPTH         = 32;
   localparam int DEFAULT_VALUE_BITS    = 16;
   localparam int DEFAULT_PRIORITY_BITS = 4;

   // Operation carried by one request beat; the last code does nothing.
   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_EXTRACT = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_NOP     = 2'd3
   } pqx_kind_type;

   // Operation broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic extract;
   } cell_ctrl_type;

endpackage

[hdl/pqx_cell.sv]
// ---------------------------------------------------------------------------
// pqx_cell
// One slot of the sorted chain. The chain holds entries in descending
// priority, equal priorities in arrival order, with the best at slot zero.
// ---------------------------------------------------------------------------
module pqx_cell
   import pqx_pkg::*;
#(
   parameter int INDEX         = 0,
   parameter int VALUE_BITS    = DEFAULT_VALUE_BITS,
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS,
   parameter int COUNT_BITS    = 6
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [COUNT_BITS-1:0]    count,
   input  logic [VALUE_BITS-1:0]    new_value,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic                     prev_keep,
   input  logic [VALUE_BITS-1:0]    prev_value,
   input  logic [PRIORITY_BITS-1:0] prev_priority,
   input  logic [VALUE_BITS-1:0]    next_value,
   input  logic [PRIORITY_BITS-1:0] next_priority,
   output logic                     keep,
   output logic [VALUE_BITS-1:0]    value,
   output logic [PRIORITY_BITS-1:0] priority_out
);

   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic                     occupied;

   // A held entry at or above the new priority stays where it is on insert.
   assign occupied = COUNT_BITS'(INDEX) < count;
   assign keep     = occupied && (priority_ff >= new_priority);

   // Slot update: hold, take the new entry, shift down, or shift up.
   always_comb begin
      value_in    = value_ff;
      priority_in = priority_ff;
      if (ctrl.insert) begin
         if (keep) begin
            value_in    = value_ff;
            priority_in = priority_ff;
         end else if (prev_keep) begin
            value_in    = new_value;
            priority_in = new_priority;
         end else begin
            value_in    = prev_value;
            priority_in = prev_priority;
         end
      end else if (ctrl.extract) begin
         value_in    = next_value;
         priority_in = next_priority;
      end
   end

   // Entry storage; contents only matter below the held count.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign value        = value_ff;
   assign priority_out = priority_ff;

endmodule

[hdl/priority_queue_extract_max_unit.sv]
// ---------------------------------------------------------------------------
// priority_queue_extract_max_unit
// Bounded stable priority queue built as a chain of sorted cells.
// ---------------------------------------------------------------------------
// Usage:
//  The req_ channel carries one operation per beat: add (value, priority),
//  extract of the highest priority entry (oldest among equal priorities),
//  or clear. Code 3 does nothing and reports the unchanged queue.
//  Every request beat yields exactly one rsp_ beat with the extracted
//  value, got_value, dropped, and the count, empty and full status after
//  the operation.
//  The response is registered and valid in the cycle after the request is
//  accepted. One request is taken per cycle while req_stall is low: every
//  cell compares its priority against the new entry and trades data with its
//  two neighbors within that cycle, so the chain of DEPTH cells settles as one.
//  The response sits in an output register; while rsp_stall holds a valid
//  response, req_stall is raised and the queue does not move.
//  Synchronous reset empties the queue and drops any pending response;
//  no clearing pass is needed and requests are taken right after reset.
// ---------------------------------------------------------------------------
`include "priority_queue_extract_max_unit_macros.svh"

module priority_queue_extract_max_unit
   import pqx_pkg::*;
#(
   parameter int DEPTH         = DEFAULT_DEPTH,
   parameter int VALUE_BITS    = DEFAULT_VALUE_BITS,
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS,
   parameter int COUNT_BITS    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_kind,
   input  logic [VALUE_BITS-1:0]    req_value_in,
   input  logic [PRIORITY_BITS-1:0] req_priority_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [VALUE_BITS-1:0]    rsp_value_out,
   output logic                     rsp_got_value,
   output logic                     rsp_dropped,
   output logic [COUNT_BITS-1:0]    rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] value_out_ff, value_out_in;
   logic                  got_value_ff, got_value_in;
   logic                  dropped_ff, dropped_in;
   logic [COUNT_BITS-1:0] entry_count_ff;
   logic                  is_empty_ff, is_full_ff;
   logic                  accept;
   cell_ctrl_type         ctrl;

   logic                     cell_keep     [DEPTH];
   logic [VALUE_BITS-1:0]    cell_value    [DEPTH];
   logic [PRIORITY_BITS-1:0] cell_priority [DEPTH];

   // A request beat is taken unless a response is waiting on a stalled receiver.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Operation decode, chain control and the next count.
   always_comb begin
      ctrl         = '0;
      count_in     = count_ff;
      value_out_in = '0;
      got_value_in = 1'b0;
      dropped_in   = 1'b0;
      case (req_kind)
         KIND_ADD: begin
            if (count_ff < FULL_COUNT) begin
               ctrl.insert = accept;
               count_in    = count_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         KIND_EXTRACT: begin
            if (count_ff != '0) begin
               ctrl.extract = accept;
               value_out_in = cell_value[0];
               got_value_in = 1'b1;
               count_in     = count_ff - 1'b1;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Chain of cells, best entry at slot zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     prev_keep;
      logic [VALUE_BITS-1:0]    prev_value, next_value;
      logic [PRIORITY_BITS-1:0] prev_priority, next_priority;

      if (i == 0) begin : g_head
         assign prev_keep     = 1'b1;
         assign prev_value    = req_value_in;
         assign prev_priority = req_priority_in;
      end else begin : g_body
         assign prev_keep     = cell_keep[i-1];
         assign prev_value    = cell_value[i-1];
         assign prev_priority = cell_priority[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value    = '0;
         assign next_priority = '0;
      end else begin : g_link
         assign next_value    = cell_value[i+1];
         assign next_priority = cell_priority[i+1];
      end

      pqx_cell #(
         .INDEX         (i),
         .VALUE_BITS    (VALUE_BITS),
         .PRIORITY_BITS (PRIORITY_BITS),
         .COUNT_BITS    (COUNT_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count_ff),
         .new_value     (req_value_in),
         .new_priority  (req_priority_in),
         .prev_keep     (prev_keep),
         .prev_value    (prev_value),
         .prev_priority (prev_priority),
         .next_value    (next_value),
         .next_priority (next_priority),
         .keep          (cell_keep[i]),
         .value         (cell_value[i]),
         .priority_out  (cell_priority[i])
      );
   end

   // Response valid holds while stalled and clears once taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on every accepted request beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         value_out_ff   <= value_out_in;
         got_value_ff   <= got_value_in;
         dropped_ff     <= dropped_in;
         entry_count_ff <= count_in;
         is_empty_ff    <= (count_in == '0);
         is_full_ff     <= (count_in == FULL_COUNT);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = value_out_ff;
   assign rsp_got_value   = got_value_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_is_empty    = is_empty_ff;
   assign rsp_is_full     = is_full_ff;

   // Checks on the count bookkeeping and the response flags.
   `PQX_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "count above depth")
   `PQX_ASSERT_NEXT(a_extract_dec, clock, reset, ctrl.extract, count_ff == $past(count_ff) - 1'b1, "extract count")
   `PQX_ASSERT_NEXT(a_drop_hold, clock, reset, accept && req_kind == KIND_ADD && count_ff == FULL_COUNT, rsp_dropped && $stable(count_ff), "full add not dropped")
   `PQX_ASSERT_SAME(a_flags_excl, clock, reset, rsp_valid_ff, !(got_value_ff && dropped_ff), "got and dropped together")
   `PQX_ASSERT_SAME(a_ctrl_excl, clock, reset, 1'b1, !(ctrl.insert && ctrl.extract), "insert and extract together")

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the priority queue extract-max unit. A shadow
// copy of the queue predicts the response of every accepted request beat,
// and each response beat is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb;
   import pqx_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_DEPTH;
   localparam int VAL_W       = DEFAULT_VALUE_BITS;
   localparam int PRIO_W      = DEFAULT_PRIORITY_BITS;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ITEM_TARGET = 450;
   localparam int IDLE_LIMIT  = 1000;
   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             got_value;
      logic             dropped;
      logic [CNT_W-1:0] count;
      logic             empty;
      logic             full;
   } pq_result_type;

   // Shadow queue that predicts each response and matches it on arrival.
   class queue_tracker_type;
      logic [VAL_W-1:0]  slot_value [QUEUE_DEPTH];
      logic [PRIO_W-1:0] slot_prio  [QUEUE_DEPTH];
      int                held;
      pq_result_type     due_results [$];
      int                error_count;
      int                served;
      int                drops;
      int                clears;
      int                full_hits;

      function new();
         held        = 0;
         error_count = 0;
         served      = 0;
         drops       = 0;
         clears      = 0;
         full_hits   = 0;
      endfunction

      task report(input string what);
         error_count++;
         if (error_count <= MAX_PRINTED) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
      endtask

      function int pending();
         return due_results.size();
      endfunction

      // Apply one accepted request to the shadow queue and queue its response.
      function void take_request(input pqx_kind_type kind, input logic [VAL_W-1:0] value,
                                 input logic [PRIO_W-1:0] prio);
         pq_result_type r;
         int            best;
         int            i;
         r = '0;
         case (kind)
            KIND_ADD: begin
               if (held < QUEUE_DEPTH) begin
                  slot_value[held] = value;
                  slot_prio[held]  = prio;
                  held++;
               end else begin
                  r.dropped = 1'b1;
                  drops++;
               end
            end
            KIND_EXTRACT: begin
               if (held > 0) begin
                  // Strict compare keeps the oldest among equal priorities.
                  best = 0;
                  for (i = 1; i < held; i++) begin
                     if (slot_prio[i] > slot_prio[best]) best = i;
                  end
                  r.value     = slot_value[best];
                  r.got_value = 1'b1;
                  for (i = best; i + 1 < held; i++) begin
                     slot_value[i] = slot_value[i + 1];
                     slot_prio[i]  = slot_prio[i + 1];
                  end
                  held--;
                  served++;
               end
            end
            KIND_CLEAR: begin
               held = 0;
               clears++;
            end
            default: begin
            end
         endcase
         r.count = CNT_W'(held);
         r.empty = (held == 0);
         r.full  = (held == QUEUE_DEPTH);
         if (r.full) full_hits++;
         due_results.push_back(r);
      endfunction

      // Compare one response beat against the oldest prediction.
      task match_response(input pq_result_type seen);
         pq_result_type want;
         if (due_results.size() == 0) begin
            report("response beat with no request outstanding");
         end else begin
            want = due_results.pop_front();
            if (seen.value !== want.value)
               report($sformatf("value_out got %h want %h", seen.value, want.value));
            if (seen.got_value !== want.got_value)
               report($sformatf("got_value got %b want %b", seen.got_value, want.got_value));
            if (seen.dropped !== want.dropped)
               report($sformatf("dropped got %b want %b", seen.dropped, want.dropped));
            if (seen.count !== want.count)
               report($sformatf("entry_count got %0d want %0d", seen.count, want.count));
            if (seen.empty !== want.empty)
               report($sformatf("is_empty got %b want %b", seen.empty, want.empty));
            if (seen.full !== want.full)
               report($sformatf("is_full got %b want %b", seen.full, want.full));
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_kind = KIND_NOP;
   logic [VAL_W-1:0]  req_value_in = '0;
   logic [PRIO_W-1:0] req_priority_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [VAL_W-1:0]  rsp_value_out;
   logic              rsp_got_value;
   logic              rsp_dropped;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic              rsp_is_empty;
   logic              rsp_is_full;

   queue_tracker_type tracker = new();
   int                sent_count = 0;
   int                idle_cycles = 0;

   priority_queue_extract_max_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value_in    (req_value_in),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_out   (rsp_value_out),
      .rsp_got_value   (rsp_got_value),
      .rsp_dropped     (rsp_dropped),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   // Free-running 10 ns clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request beat, with a random gap first, and wait for it to go in.
   task automatic send_item(input pqx_kind_type kind, input logic [VAL_W-1:0] value,
                            input logic [PRIO_W-1:0] prio);
      bit quiet;
      quiet = (sent_count >= 200 && sent_count < 300);
      while (!quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_value_in    <= value;
      req_priority_in <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Receiver stalls: random, one long hold that backs up the queue, one quiet run.
   initial begin : rsp_side
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 300 && cyc < 360) begin
            rsp_stall <= 1'b1;
         end else if (cyc >= 500 && cyc < 700) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 16);
         end
      end
   end

   // Sample both channels at the edge; the watchdog ends a hung run.
   always @(posedge clock) begin
      pq_result_type seen;
      bit            moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.take_request(pqx_kind_type'(req_kind), req_value_in, req_priority_in);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen.value     = rsp_value_out;
            seen.got_value = rsp_got_value;
            seen.dropped   = rsp_dropped;
            seen.count     = rsp_entry_count;
            seen.empty     = rsp_is_empty;
            seen.full      = rsp_is_full;
            tracker.match_response(seen);
            moved = 1'b1;
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("[priority_queue_extract_max_unit] ERROR");
         $finish;
      end
   end

   // Reset, directed requests, then bursts of random requests.
   initial begin : req_side
      int           mode;
      int           burst;
      int           roll;
      int           j;
      bit           narrow;
      pqx_kind_type kind;
      logic [PRIO_W-1:0] prio;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty extract, no-op, field extremes, ties, clear.
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_NOP, 16'hFFFF, 4'hF);
      send_item(KIND_ADD, 16'hFFFF, 4'hF);
      send_item(KIND_ADD, 16'h0000, 4'h0);
      send_item(KIND_ADD, 16'h1234, 4'h7);
      send_item(KIND_ADD, 16'h5678, 4'h7);
      send_item(KIND_ADD, 16'h9ABC, 4'h7);
      send_item(KIND_ADD, 16'hAAAA, 4'hF);
      send_item(KIND_EXTRACT, 16'h0000, 4'h0);
      send_item(KIND_EXTRACT, 16'hFFFF, 4'hF);
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_NOP, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_CLEAR, 16'hFFFF, 4'hF);
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_ADD, 16'h5555, 4'h0);
      send_item(KIND_ADD, 16'hC3C3, 4'h8);
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));
      send_item(KIND_EXTRACT, VAL_W'($urandom), PRIO_W'($urandom));

      // Random bursts: filling, draining or mixed, with narrow priorities for ties.
      while (sent_count < ITEM_TARGET) begin
         mode   = $urandom_range(0, 2);
         burst  = $urandom_range(10, 50);
         narrow = ($urandom_range(0, 1) == 1);
         for (j = 0; j < burst && sent_count < ITEM_TARGET; j++) begin
            roll = $urandom_range(0, 99);
            if (roll >= 98) begin
               kind = KIND_CLEAR;
            end else if (roll >= 96) begin
               kind = KIND_NOP;
            end else if (mode == 0) begin
               kind = (roll < 82) ? KIND_ADD : KIND_EXTRACT;
            end else if (mode == 1) begin
               kind = (roll < 18) ? KIND_ADD : KIND_EXTRACT;
            end else begin
               kind = (roll < 50) ? KIND_ADD : KIND_EXTRACT;
            end
            prio = narrow ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom);
            send_item(kind, VAL_W'($urandom), prio);
         end
      end
      req_valid <= 1'b0;

      // Drain the outstanding responses, then let the response register settle.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d requests: %0d extracts returned an entry, %0d clears.",
               sent_count, tracker.served, tracker.clears);
      $display("Queue reported full %0d times and %0d adds were dropped; %0d mismatches.",
               tracker.full_hits, tracker.drops, tracker.error_count);
      if (tracker.error_count == 0) begin
         $display("[priority_queue_extract_max_unit] OK");
      end else begin
         $display("[priority_queue_extract_max_unit] ERROR");
      end
      $finish;
   end

endmodule
